// File: rtl/smc_pkg.sv
// smc_pkg: shared types and constants for the set membership table.
// Used by smc_cell and set_membership_table; no dependencies.
package smc_pkg;

   localparam int ELEM_W = 32;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic              lookup;    // item accepted: compare element now
      logic              do_delete; // commit a delete of the hit entry
      logic              do_insert; // commit an append of the element
      logic [ELEM_W-1:0] element;
   } smc_ctl_type;

endpackage

// File: rtl/smc_cell.sv
// smc_cell: one slot of the set; holds an entry, its match flag, and shifts
// down from its upper neighbor on delete. Depends on smc_pkg.
module smc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  smc_pkg::smc_ctl_type       ctl,
   input  logic                       occupied,
   input  logic                       append_here,
   input  logic [smc_pkg::ELEM_W-1:0] lookup_element,
   input  logic [smc_pkg::ELEM_W-1:0] upper_entry,
   input  logic                       seen_in,
   output logic                       seen_out,
   output logic                       hit,
   output logic [smc_pkg::ELEM_W-1:0] entry
);
   import smc_pkg::*;

   logic [ELEM_W-1:0] entry_ff, entry_in;
   logic              hit_ff, hit_in;

   // a hit at this slot or any lower one means this slot shifts on delete
   assign seen_out = seen_in | hit_ff;
   assign hit      = hit_ff;
   assign entry    = entry_ff;

   always_comb begin
      hit_in = hit_ff;
      if (ctl.lookup) begin
         hit_in = occupied && (entry_ff == lookup_element);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.do_delete && seen_out) begin
         entry_in = upper_entry;
      end else if (ctl.do_insert && append_here) begin
         entry_in = ctl.element;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/set_membership_table.sv
// set_membership_table: top level; a row of smc_cell slots plus the
// request/result control. Depends on smc_pkg and smc_cell.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_kind, req_element
//   rsp     | out       | rsp_valid, rsp_stall, rsp_was_present, rsp_stored_count,
//           |           | rsp_is_empty, rsp_is_full, rsp_dropped
//
// One item at a time: on the accept edge every cell compares its entry with the
// element; at the following commit edge the set is updated and the result loaded.
// The update waits while a previous result is still stalled in the output register.
// Delete shifts all slots above the hit down by one in that single update cycle.
// Reset empties the set; entries are not cleared, only the count.
module set_membership_table #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smc_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [smc_pkg::ELEM_W-1:0]   req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_was_present,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_stored_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic                                rsp_dropped
);
   import smc_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_UPD  = 1'b1;

   logic              state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [KIND_W-1:0] kind_ff;
   logic [ELEM_W-1:0] elem_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              was_present_ff, was_present_in;
   logic [CW-1:0]     stored_count_ff;
   logic              is_empty_ff, is_full_ff, dropped_ff, dropped_in;

   logic              accept, commit, present, full;
   smc_ctl_type       ctl;

   logic [CAPACITY-1:0] hit_vec, occupied_vec, append_vec;
   logic [CAPACITY:0]   seen;
   logic [ELEM_W-1:0]   entries [CAPACITY];

   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff == ST_UPD);
   assign commit  = (state_ff == ST_UPD) && !(rsp_valid_ff && rsp_stall);
   assign present = (kind_ff != KIND_CLEAR) && (|hit_vec);
   assign full    = (count_ff == CAP_COUNT);

   always_comb begin
      ctl.lookup    = accept;
      ctl.do_delete = commit && (kind_ff == KIND_DELETE) && present;
      ctl.do_insert = commit && (kind_ff == KIND_INSERT) && !present && !full;
      ctl.element   = elem_ff;
   end

   assign seen[0] = 1'b0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ELEM_W-1:0] upper;
      if (g == CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid
         assign upper = entries[g+1];
      end

      assign occupied_vec[g] = (CW'(g) < count_ff);
      assign append_vec[g]   = (CW'(g) == count_ff);

      smc_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl),
         .occupied       (occupied_vec[g]),
         .append_here    (append_vec[g]),
         .lookup_element (req_element),
         .upper_entry    (upper),
         .seen_in        (seen[g]),
         .seen_out       (seen[g+1]),
         .hit            (hit_vec[g]),
         .entry          (entries[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = 1'b0;
      case (kind_ff)
         KIND_INSERT: begin
            if (!present) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         KIND_DELETE: begin
            if (present) begin
               count_in = count_ff - CW'(1);
            end
         end
         KIND_CLEAR: count_in = '0;
         default:    count_in = count_ff;
      endcase
   end

   assign was_present_in = present;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         elem_ff <= req_element;
      end
      if (commit) begin
         was_present_ff  <= was_present_in;
         stored_count_ff <= count_in;
         is_empty_ff     <= (count_in == '0);
         is_full_ff      <= (count_in == CAP_COUNT);
         dropped_ff      <= dropped_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = was_present_ff;
   assign rsp_stored_count = stored_count_ff;
   assign rsp_is_empty     = is_empty_ff;
   assign rsp_is_full      = is_full_ff;
   assign rsp_dropped      = dropped_ff;

   // entries are distinct, so at most one slot can match
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one slot matched");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("held count above capacity");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPD))
      else $error("result without an update");

   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dropped_ff |-> is_full_ff && !was_present_ff)
      else $error("dropped insert with inconsistent flags");

endmodule
